// File: src/mmgn_pkg.sv
package mmgn_pkg;

  localparam int MAX_PIXELS  = 4096;
  localparam int SAMPLE_BITS = 16;
  localparam int ADDR_W      = $clog2(MAX_PIXELS);
  localparam int CNT_W       = $clog2(MAX_PIXELS + 1);
  localparam int SPAN_W      = SAMPLE_BITS + 1;
  localparam int GREY_W      = 8;
  localparam int PROD_W      = SPAN_W + GREY_W;
  localparam int STEP_W      = $clog2(GREY_W);

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EMIT = 1'b1;

  typedef struct packed {
    logic              start;
    logic [SPAN_W-1:0] off;
    logic [SPAN_W-1:0] span;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [GREY_W-1:0] grey;
  } div_rsp_t;

endpackage

// File: src/mmgn_if.sv
interface mmgn_in_if;
  logic                                       valid;
  logic                                       ready;
  logic                                       operation;
  logic signed [mmgn_pkg::SAMPLE_BITS-1:0]    sample;

  modport source (output valid, output operation, output sample, input ready);
  modport sink (input valid, input operation, input sample, output ready);
endinterface

interface mmgn_out_if;
  logic                        valid;
  logic                        ready;
  logic [mmgn_pkg::GREY_W-1:0] grey;
  logic                        last_pixel;
  logic                        frame_empty;

  modport source (output valid, output grey, output last_pixel, output frame_empty,
                  input ready);
  modport sink (input valid, input grey, input last_pixel, input frame_empty,
                output ready);
endinterface

// File: src/mmgn_sample_ram.sv
module mmgn_sample_ram (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [mmgn_pkg::ADDR_W-1:0]      waddr_i,
  input  logic [mmgn_pkg::SAMPLE_BITS-1:0] wdata_i,
  input  logic                             re_i,
  input  logic [mmgn_pkg::ADDR_W-1:0]      raddr_i,
  output logic [mmgn_pkg::SAMPLE_BITS-1:0] rdata_o
);

  logic [mmgn_pkg::SAMPLE_BITS-1:0] mem [mmgn_pkg::MAX_PIXELS];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// File: src/mmgn_div.sv
module mmgn_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mmgn_pkg::div_req_t req_i,
  output mmgn_pkg::div_rsp_t rsp_o
);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [mmgn_pkg::STEP_W-1:0]   cnt_q, cnt_d;
  logic [mmgn_pkg::PROD_W-1:0]   rem_q, rem_d;
  logic [mmgn_pkg::PROD_W-1:0]   dvs_q, dvs_d;
  logic [mmgn_pkg::GREY_W-1:0]   quo_q, quo_d;
  logic                          flat_q, flat_d;
  logic [mmgn_pkg::PROD_W-1:0]   off_ext;
  logic                          ge;

  assign off_ext = mmgn_pkg::PROD_W'(req_i.off);
  assign ge      = rem_q >= dvs_q;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    flat_d = flat_q;
    if (req_i.start) begin
      // off * 255 as a shift and subtract
      rem_d  = (off_ext << mmgn_pkg::GREY_W) - off_ext;
      dvs_d  = mmgn_pkg::PROD_W'(req_i.span) << (mmgn_pkg::GREY_W - 1);
      quo_d  = '0;
      flat_d = (req_i.span == '0);
      cnt_d  = mmgn_pkg::STEP_W'(mmgn_pkg::GREY_W - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (ge) begin
        rem_d = rem_q - dvs_q;
      end
      quo_d = {quo_q[mmgn_pkg::GREY_W-2:0], ge};
      dvs_d = dvs_q >> 1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
    quo_q  <= quo_d;
    flat_q <= flat_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.grey = flat_q ? '0 : quo_q;

endmodule

// File: src/minmax_greyscale_normalizer.sv
// channel | dir | payload                          | handshake
// in_i    | in  | operation, sample                | valid/ready
// out_o   | out | grey, last_pixel, frame_empty    | valid/ready
// a load writes the sample memory and updates min and max, unless the frame is full
// an emit runs in order: memory read, offset clamp, 8 restoring divide steps, output load
// an emit on an empty frame gives its item in the next cycle
// reset clears counts, pointer and extremes; the sample memory is not cleared
// a stalled output holds a finished emit in its final state and the input waits
module minmax_greyscale_normalizer (
  input  logic            clk_i,
  input  logic            rst_ni,
  mmgn_in_if.sink         in_i,
  mmgn_out_if.source      out_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]                               state_q, state_d;
  logic [mmgn_pkg::CNT_W-1:0]               pixel_count_q, pixel_count_d;
  logic [mmgn_pkg::ADDR_W-1:0]              read_pointer_q, read_pointer_d;
  logic signed [mmgn_pkg::SAMPLE_BITS-1:0]  min_seen_q, min_seen_d;
  logic signed [mmgn_pkg::SAMPLE_BITS-1:0]  max_seen_q, max_seen_d;
  logic signed [mmgn_pkg::SAMPLE_BITS-1:0]  min_cap_q, min_cap_d;
  logic [mmgn_pkg::SPAN_W-1:0]              span_q, span_d;
  logic                                     last_q, last_d;

  logic                                     out_valid_q, out_valid_d;
  logic [mmgn_pkg::GREY_W-1:0]              grey_q, grey_d;
  logic                                     last_pixel_q, last_pixel_d;
  logic                                     frame_empty_q, frame_empty_d;

  logic                                     accept, is_emit, empty, full, out_free;
  logic                                     is_last, ram_we, ram_re, out_load;
  logic [mmgn_pkg::SAMPLE_BITS-1:0]         rdata;
  logic signed [mmgn_pkg::SPAN_W-1:0]       diff;
  logic [mmgn_pkg::SPAN_W-1:0]              off;
  mmgn_pkg::div_req_t                       div_req;
  mmgn_pkg::div_rsp_t                       div_rsp;

  assign is_emit  = (in_i.operation == mmgn_pkg::OP_EMIT);
  assign empty    = (pixel_count_q == '0);
  assign full     = (pixel_count_q == mmgn_pkg::CNT_W'(mmgn_pkg::MAX_PIXELS));
  assign out_free = !out_valid_q || out_o.ready;
  assign is_last  = (mmgn_pkg::CNT_W'(read_pointer_q) + 1'b1) >= pixel_count_q;

  assign in_i.ready = (state_q == S_IDLE) && !(is_emit && empty && !out_free);
  assign accept     = in_i.valid && in_i.ready;
  assign ram_we     = accept && !is_emit && !full;
  assign ram_re     = accept && is_emit && !empty;

  mmgn_sample_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (pixel_count_q[mmgn_pkg::ADDR_W-1:0]),
    .wdata_i (in_i.sample),
    .re_i    (ram_re),
    .raddr_i (read_pointer_q),
    .rdata_o (rdata)
  );

  // offset from the minimum, clamped to the span
  assign diff = {rdata[mmgn_pkg::SAMPLE_BITS-1], rdata}
              - {min_cap_q[mmgn_pkg::SAMPLE_BITS-1], min_cap_q};
  always_comb begin
    if (diff[mmgn_pkg::SPAN_W-1]) begin
      off = '0;
    end else if (mmgn_pkg::SPAN_W'(diff) > span_q) begin
      off = span_q;
    end else begin
      off = mmgn_pkg::SPAN_W'(diff);
    end
  end

  assign div_req.start = (state_q == S_RD);
  assign div_req.off   = off;
  assign div_req.span  = span_q;

  mmgn_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    state_d        = state_q;
    pixel_count_d  = pixel_count_q;
    read_pointer_d = read_pointer_q;
    min_seen_d     = min_seen_q;
    max_seen_d     = max_seen_q;
    min_cap_d      = min_cap_q;
    span_d         = span_q;
    last_d         = last_q;
    out_load       = 1'b0;
    grey_d         = grey_q;
    last_pixel_d   = last_pixel_q;
    frame_empty_d  = frame_empty_q;

    case (state_q)
      S_IDLE: begin
        if (accept && !is_emit) begin
          if (!full) begin
            if (empty) begin
              min_seen_d = in_i.sample;
              max_seen_d = in_i.sample;
            end else begin
              if (in_i.sample > max_seen_q) begin
                max_seen_d = in_i.sample;
              end
              if (in_i.sample < min_seen_q) begin
                min_seen_d = in_i.sample;
              end
            end
            pixel_count_d = pixel_count_q + 1'b1;
          end
        end else if (accept && empty) begin
          out_load      = 1'b1;
          grey_d        = '0;
          last_pixel_d  = 1'b0;
          frame_empty_d = 1'b1;
        end else if (accept) begin
          min_cap_d = min_seen_q;
          span_d    = mmgn_pkg::SPAN_W'({max_seen_q[mmgn_pkg::SAMPLE_BITS-1], max_seen_q}
                    - {min_seen_q[mmgn_pkg::SAMPLE_BITS-1], min_seen_q});
          last_d    = is_last;
          if (is_last) begin
            pixel_count_d  = '0;
            read_pointer_d = '0;
            min_seen_d     = '0;
            max_seen_d     = '0;
          end else begin
            read_pointer_d = read_pointer_q + 1'b1;
          end
          state_d = S_RD;
        end
      end
      S_RD: begin
        state_d = S_DIV;
      end
      S_DIV: begin
        if (div_rsp.done) begin
          if (out_free) begin
            out_load      = 1'b1;
            grey_d        = div_rsp.grey;
            last_pixel_d  = last_q;
            frame_empty_d = 1'b0;
            state_d       = S_IDLE;
          end else begin
            state_d = S_OUT;
          end
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_load      = 1'b1;
          grey_d        = div_rsp.grey;
          last_pixel_d  = last_q;
          frame_empty_d = 1'b0;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      pixel_count_q  <= '0;
      read_pointer_q <= '0;
      min_seen_q     <= '0;
      max_seen_q     <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      pixel_count_q  <= pixel_count_d;
      read_pointer_q <= read_pointer_d;
      min_seen_q     <= min_seen_d;
      max_seen_q     <= max_seen_d;
      out_valid_q    <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    min_cap_q <= min_cap_d;
    span_q    <= span_d;
    last_q    <= last_d;
    if (out_load) begin
      grey_q        <= grey_d;
      last_pixel_q  <= last_pixel_d;
      frame_empty_q <= frame_empty_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.grey        = grey_q;
  assign out_o.last_pixel  = last_pixel_q;
  assign out_o.frame_empty = frame_empty_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pixel_count_q <= mmgn_pkg::CNT_W'(mmgn_pkg::MAX_PIXELS))
    else $error("pixel count above capacity");

  a_ptr_below_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pixel_count_q != '0) |-> (mmgn_pkg::CNT_W'(read_pointer_q) < pixel_count_q))
    else $error("read pointer past loaded samples");

  a_count_frozen_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |=> $stable(pixel_count_q))
    else $error("frame changed while an emit is in flight");

  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == S_DIV))
    else $error("divider finished outside the divide state");

endmodule
